FILE: hdl/assert_macros.svh
// Assertion helpers. Each use expects signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define CLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLR_ASSERT_ALWAYS(lbl, expr)
`define CLR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/clr_pkg.sv
`default_nettype none
package clr_pkg;

  typedef enum logic [1:0] {
    OP_ONLINE  = 2'd0,
    OP_LEASE   = 2'd1,
    OP_RELEASE = 2'd2
  } clr_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2
  } clr_status_e;

  typedef enum logic [1:0] {
    ROLE_OFF  = 2'd0,
    ROLE_HSK  = 2'd1,
    ROLE_IDLE = 2'd2,
    ROLE_HOT  = 2'd3
  } clr_role_e;

  localparam logic [31:0] OWNER_NONE = 32'hFFFF_FFFF;
  localparam int MASK_W = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  core_index;
    logic [31:0] owner;
  } clr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  hot_mask;
    logic [7:0]  isolated_mask;
    logic [3:0]  online_count;
    logic [34:0] migration_total;
  } clr_out_t;

endpackage
`default_nettype wire

FILE: hdl/clr_table.sv
`default_nettype none
`include "assert_macros.svh"
module clr_table
  import clr_pkg::*;
#(
  parameter int CORES = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     upd,
  input  clr_in_t  item,
  output clr_out_t res
);

  localparam logic [CORES-1:0] CORE0_BIT = {{(CORES-1){1'b0}}, 1'b1};

  logic [CORES-1:0] online_r, online_nxt;
  logic [CORES-1:0] ov_r, ov_nxt;
  logic [CORES-1:0] iso_r, iso_nxt;
  clr_role_e        role_r   [CORES];
  clr_role_e        role_nxt [CORES];
  logic [31:0]      owner_r   [CORES];
  logic [31:0]      owner_nxt [CORES];
  logic [31:0]      mig_r   [CORES];
  logic [31:0]      mig_nxt [CORES];
  logic [3:0]       cnt_r, cnt_nxt;
  logic [34:0]      total_r, total_nxt;

  logic [CORES-1:0] hit;
  logic             idx_ok;
  logic             sel_online;
  logic             sel_ov;
  clr_role_e        sel_role;
  logic [31:0]      sel_owner;
  logic [31:0]      sel_mig;
  clr_status_e      st;
  logic             do_on, do_lease, do_rel, do_mig;

  // Core 0 never matches: it cannot be brought online or leased.
  always_comb begin
    hit        = '0;
    sel_online = 1'b0;
    sel_ov     = 1'b0;
    sel_role   = ROLE_OFF;
    sel_owner  = '0;
    sel_mig    = '0;
    for (int c = 1; c < CORES; c++) begin
      hit[c] = (item.core_index == 8'(c));
      if (hit[c]) begin
        sel_online = online_r[c];
        sel_ov     = ov_r[c];
        sel_role   = role_r[c];
        sel_owner  = owner_r[c];
        sel_mig    = mig_r[c];
      end
    end
    idx_ok = |hit;
  end

  always_comb begin
    st       = ST_INVALID;
    do_on    = 1'b0;
    do_lease = 1'b0;
    do_rel   = 1'b0;
    do_mig   = 1'b0;
    unique case (clr_op_e'(item.op))
      OP_ONLINE: begin
        if (idx_ok) begin
          st    = ST_OK;
          do_on = upd;
        end
      end
      OP_LEASE: begin
        if (!idx_ok || item.owner == OWNER_NONE || !sel_online ||
            sel_role != ROLE_IDLE) begin
          st = ST_INVALID;
        end else if (sel_ov && sel_owner != item.owner) begin
          st     = ST_BUSY;
          do_mig = upd;
        end else begin
          st       = ST_OK;
          do_lease = upd;
        end
      end
      OP_RELEASE: begin
        if (idx_ok && sel_online && sel_role == ROLE_HOT && sel_ov &&
            sel_owner == item.owner) begin
          st     = ST_OK;
          do_rel = upd;
        end
      end
      default: st = ST_INVALID;
    endcase
  end

  always_comb begin
    online_nxt = online_r;
    ov_nxt     = ov_r;
    iso_nxt    = iso_r;
    role_nxt   = role_r;
    owner_nxt  = owner_r;
    mig_nxt    = mig_r;
    for (int c = 0; c < CORES; c++) begin
      if (hit[c]) begin
        if (do_on || do_rel) begin
          online_nxt[c] = 1'b1;
          role_nxt[c]   = ROLE_IDLE;
          ov_nxt[c]     = 1'b0;
          owner_nxt[c]  = '0;
          iso_nxt[c]    = 1'b1;
        end
        if (do_lease) begin
          role_nxt[c]  = ROLE_HOT;
          ov_nxt[c]    = 1'b1;
          owner_nxt[c] = item.owner;
          iso_nxt[c]   = 1'b1;
        end
        if (do_mig) begin
          mig_nxt[c] = mig_r[c] + 32'd1;
        end
      end
    end
  end

  // Running totals stand in for a sum over the table. A counter that wraps
  // from all ones to zero takes 2^32 - 1 off the total.
  always_comb begin
    cnt_nxt   = cnt_r + 4'(do_on && !sel_online);
    total_nxt = total_r;
    if (do_mig) begin
      if (sel_mig == '1) begin
        total_nxt = total_r - 35'h0_FFFF_FFFF;
      end else begin
        total_nxt = total_r + 35'd1;
      end
    end
  end

  always_comb begin
    res                 = '0;
    res.status          = st;
    res.online_count    = cnt_nxt;
    res.migration_total = total_nxt;
    for (int c = 0; c < MASK_W; c++) begin
      if (c < CORES) begin
        res.hot_mask[c]      = (role_nxt[c] == ROLE_HOT);
        res.isolated_mask[c] = iso_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= CORE0_BIT;
      ov_r     <= '0;
      iso_r    <= '0;
      cnt_r    <= 4'd1;
      total_r  <= '0;
      for (int c = 0; c < CORES; c++) begin
        role_r[c] <= (c == 0) ? ROLE_HSK : ROLE_OFF;
        mig_r[c]  <= '0;
      end
    end else begin
      online_r <= online_nxt;
      ov_r     <= ov_nxt;
      iso_r    <= iso_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      role_r   <= role_nxt;
      mig_r    <= mig_nxt;
    end
  end

  // Owner ids are only looked at while their owner-valid bit is set.
  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
  end

  `CLR_ASSERT_ALWAYS(a_core0_hsk, online_r[0] && role_r[0] == ROLE_HSK)
  `CLR_ASSERT_ALWAYS(a_cnt_track, cnt_r == 4'($countones(online_r)))
  `CLR_ASSERT_ALWAYS(a_iso_online, iso_r == (online_r & ~CORE0_BIT))
  `CLR_ASSERT_NEXT(a_busy_counts, upd && st == ST_BUSY, total_r != $past(total_r))

endmodule
`default_nettype wire

FILE: hdl/core_lease_registry_top.sv
// Channel  | Direction | Handshake          | Word
// in_      | input     | in_valid, in_stall | clr_in_t: op, core_index, owner
// out_     | output    | out_valid, out_stall | clr_out_t: status, masks, count, total
//
// One word is taken every cycle while the result side keeps up; a result
// passes through the input register and the table update into the result
// register, and is taken at an edge where out_stall is low.
// After reset core 0 is online as housekeeping and all other cores are offline;
// the block accepts words in the first cycle after reset.
// A stall on the result side holds the result register and, once the input
// register is also full, raises in_stall in the same cycle.
`default_nettype none
module core_lease_registry_top
  import clr_pkg::*;
#(
  parameter int CORES = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  clr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output clr_out_t out_data
);

  logic     s1_v_r, s1_v_nxt;
  clr_in_t  s1_data_r;
  logic     out_valid_r, out_valid_nxt;
  clr_out_t out_data_r;
  clr_out_t res;
  logic     adv;
  logic     in_take;

  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt      = in_take ? 1'b1 : (s1_v_r && !adv);
    out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  clr_table #(
    .CORES(CORES)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .upd  (adv),
    .item (s1_data_r),
    .res  (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
